[src/flp_pkg.sv]
package flp_pkg;

    localparam int DEF_MAX_PAGES  = 1024;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = 11'd1024;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 1'd1;

endpackage

[src/flp_req_if.sv]
interface flp_req_if;
    logic                          valid;
    logic                          ready;
    logic [flp_pkg::OP_W-1:0]      operation;
    logic [flp_pkg::ADDR_W-1:0]    page_address;

    modport source (output valid, output operation, output page_address, input ready);
    modport sink   (input valid, input operation, input page_address, output ready);
endinterface

[src/flp_rsp_if.sv]
interface flp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [flp_pkg::ADDR_W-1:0]    allocated_address;
    logic [flp_pkg::COUNT_W-1:0]   pages_free;
    logic [flp_pkg::STAT_W-1:0]    status;

    modport source (output valid, output allocated_address, output pages_free,
                    output status, input ready);
    modport sink   (input valid, input allocated_address, input pages_free,
                    input status, output ready);
endinterface

[src/free_list_page_allocator.sv]
// LIFO page frame allocator. Each request beat carries an operation: allocate pops
// the head page and returns base_address + (index << PAGE_SHIFT), free maps an
// address to a page index and pushes it, initialize links pages 0 .. n-1 in
// ascending order with page 0 at the head, where n is page_count capped at
// MAX_PAGES. Every request gives exactly one response beat with the free count
// after it and a status: empty-list allocate and out-of-range free are rejected
// and leave the state alone; double frees are not detected. The next links sit in
// a single-port-write, registered-read memory of MAX_PAGES entries. Allocate, free
// and the unused code go through accept, then link read result or link write and
// response load; initialize puts a write sweep of one link entry per cycle between
// the two. A new request is taken while the previous response still waits; a
// response that finds the output register full stalls the block until the output
// is taken. Configuration must be written only while idle, which is not enforced.
module free_list_page_allocator #(
    parameter int MAX_PAGES  = flp_pkg::DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = flp_pkg::DEF_PAGE_SHIFT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    flp_req_if.sink                          i_req,
    flp_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [flp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [flp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // index width addresses the table, link width also holds the end marker
    localparam int IW = $clog2(MAX_PAGES);
    localparam int LW = $clog2(MAX_PAGES + 1);
    localparam logic [LW-1:0] LINK_END = LW'(MAX_PAGES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_INIT = 2'd2;

    // control state
    logic [1:0]                      r_state, n_state;
    logic [LW-1:0]                   r_head, n_head;
    logic [flp_pkg::COUNT_W-1:0]     r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    logic [flp_pkg::ADDR_W-1:0]      r_base, n_base;
    logic [flp_pkg::COUNT_W-1:0]     r_page_count, n_page_count;

    // captured request and sweep index
    logic [flp_pkg::OP_W-1:0]        r_op, n_op;
    logic [flp_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [IW-1:0]                   r_idx, n_idx;

    // response payload
    logic [flp_pkg::ADDR_W-1:0]      r_out_addr, n_out_addr;
    logic [flp_pkg::COUNT_W-1:0]     r_out_count, n_out_count;
    logic [flp_pkg::STAT_W-1:0]      r_out_status, n_out_status;

    // link memory ports
    logic                            w_we;
    logic [IW-1:0]                   w_waddr;
    logic [LW-1:0]                   w_wdata;
    logic                            w_re;
    logic [LW-1:0]                   w_rdata;

    logic [LW-1:0]                   w_n;
    logic                            w_accept;
    logic                            w_slot;
    logic                            w_head_empty;
    logic                            w_last;
    logic [LW-1:0]                   w_idx_next;
    logic [IW-1:0]                   w_free_idx;
    logic                            w_in_range;
    logic [flp_pkg::ADDR_W-1:0]      w_alloc_address;

    flp_link_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (IW),
        .DW    (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (w_rdata)
    );

    flp_addr_unit #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .IW         (IW),
        .LW         (LW)
    ) u_addr_unit (
        .i_base          (r_base),
        .i_page_address  (r_addr),
        .i_head          (r_head),
        .i_n             (w_n),
        .o_free_idx      (w_free_idx),
        .o_in_range      (w_in_range),
        .o_alloc_address (w_alloc_address)
    );

    // effective page count, capped at the table depth
    assign w_n = (32'(r_page_count) > 32'(MAX_PAGES)) ? LINK_END : LW'(r_page_count);

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    // the response register is free now or frees at this edge
    assign w_slot       = !r_out_valid || o_rsp.ready;
    assign w_head_empty = (r_head >= LINK_END);
    assign w_idx_next   = LW'(r_idx) + LW'(1);
    assign w_last       = (w_idx_next == w_n);

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.allocated_address = r_out_addr;
    assign o_rsp.pages_free        = r_out_count;
    assign o_rsp.status            = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_base       = r_base;
        n_page_count = r_page_count;
        n_op         = r_op;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_out_addr   = r_out_addr;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = w_idx_next;
        w_re         = 1'b0;

        // config writes must only arrive while idle, this block does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flp_pkg::CFG_BASE_ADDRESS: n_base = i_cfg_data;
                flp_pkg::CFG_PAGE_COUNT:   n_page_count = i_cfg_data[flp_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_req.operation;
                    n_addr = i_req.page_address;
                    n_idx  = '0;
                    // launch the head link read, data is back in the execute cycle
                    w_re   = (i_req.operation == flp_pkg::OP_ALLOC) && !w_head_empty;
                    if (i_req.operation == flp_pkg::OP_INIT && w_n != '0) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_INIT: begin
                // one link per cycle, last page points at the end marker
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_last ? LINK_END : w_idx_next;
                n_idx   = w_idx_next[IW-1:0];
                if (w_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = flp_pkg::ST_OK;
                    n_state      = S_IDLE;
                    unique case (r_op)
                        flp_pkg::OP_ALLOC: begin
                            if (w_head_empty) begin
                                n_out_status = flp_pkg::ST_EMPTY;
                            end else begin
                                n_head     = w_rdata;
                                n_count    = r_count - flp_pkg::COUNT_W'(1);
                                n_out_addr = w_alloc_address;
                            end
                        end
                        flp_pkg::OP_FREE: begin
                            if (w_in_range) begin
                                w_we    = 1'b1;
                                w_waddr = w_free_idx;
                                w_wdata = r_head;
                                n_head  = LW'(w_free_idx);
                                n_count = r_count + flp_pkg::COUNT_W'(1);
                            end else begin
                                n_out_status = flp_pkg::ST_RANGE;
                            end
                        end
                        flp_pkg::OP_INIT: begin
                            n_head  = (w_n != '0) ? '0 : LINK_END;
                            n_count = flp_pkg::COUNT_W'(w_n);
                        end
                        default: ;
                    endcase
                    n_out_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= LINK_END;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_base       <= '0;
            r_page_count <= flp_pkg::PAGE_COUNT_RESET;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_base       <= n_base;
            r_page_count <= n_page_count;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_out_addr   <= n_out_addr;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // head is a page index or the end marker, never beyond
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LINK_END)
        else $error("list head beyond end marker");

    // link table is never written while a request can be taken
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE))
        else $error("link write while idle");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    // rejected allocate carries a zero address
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == flp_pkg::ST_EMPTY) |-> (o_rsp.allocated_address == '0))
        else $error("empty allocate returned an address");

endmodule

[src/flp_link_ram.sv]
module flp_link_ram #(
    parameter int DEPTH = flp_pkg::DEF_MAX_PAGES,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/flp_addr_unit.sv]
module flp_addr_unit #(
    parameter int PAGE_SHIFT = flp_pkg::DEF_PAGE_SHIFT,
    parameter int IW         = $clog2(flp_pkg::DEF_MAX_PAGES),
    parameter int LW         = $clog2(flp_pkg::DEF_MAX_PAGES + 1)
) (
    input  logic [flp_pkg::ADDR_W-1:0] i_base,
    input  logic [flp_pkg::ADDR_W-1:0] i_page_address,
    input  logic [LW-1:0]              i_head,
    input  logic [LW-1:0]              i_n,
    output logic [IW-1:0]              o_free_idx,
    output logic                       o_in_range,
    output logic [flp_pkg::ADDR_W-1:0] o_alloc_address
);

    logic [flp_pkg::ADDR_W-1:0] w_offset;
    logic [flp_pkg::ADDR_W-1:0] w_idx_full;

    // address to page index, offset bits below the page size dropped
    assign w_offset   = i_page_address - i_base;
    assign w_idx_full = w_offset >> PAGE_SHIFT;
    assign o_in_range = w_idx_full < flp_pkg::ADDR_W'(i_n);
    assign o_free_idx = w_idx_full[IW-1:0];

    // page index to address, wraps modulo 2^32
    assign o_alloc_address = i_base + (flp_pkg::ADDR_W'(i_head) << PAGE_SHIFT);

endmodule
